// ===== hdl/scpb_pkg.sv =====
`timescale 1ns / 1ps
package scpb_pkg;
	localparam int SLOTS_DEF = 8;
	localparam int RECORD_BITS_DEF = 16;
	localparam int REC_W = 16;
	localparam int SLOT_W = 3;
	localparam int QDEPTH = 2;

	localparam logic [1:0] MODE_READ = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_FLUSH = 2'd2;

	typedef struct packed {
		logic [1:0]       mode;
		logic [REC_W-1:0] record_number;
	} in_item_t;

	typedef struct packed {
		logic             hit;
		logic [SLOT_W-1:0] slot;
		logic             writeback_valid;
		logic [REC_W-1:0] writeback_record;
		logic [31:0]      hit_total;
		logic [31:0]      fault_total;
		logic             last;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_ACCESS = 2'd0,
		OP_FLUSH  = 2'd1,
		OP_NOP    = 2'd2
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             is_write;
		logic [REC_W-1:0] rec;
	} cmd_t;
endpackage

// ===== hdl/second_chance_page_buffer_top.sv =====
`timescale 1ns / 1ps
// read/write hit or free-slot insert: slots are searched upward from slot 0
// full-buffer insert: find, second-chance scan (up to 2*SLOTS skips), shift down
// flush: one beat per dirty slot (one empty beat if none); one item in work at a time
// a two-entry queue decouples input acceptance from the slot walker
// arst_n clears all valid, reference and dirty bits, counters and the root register
module second_chance_page_buffer_top #(
	parameter int SLOTS = scpb_pkg::SLOTS_DEF,
	parameter int RECORD_BITS = scpb_pkg::RECORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  scpb_pkg::in_item_t  in_data,
	input  logic                in_valid,
	output logic                in_ready,
	output scpb_pkg::out_item_t out_data,
	output logic                out_valid,
	input  logic                out_ready,
	input  logic [RECORD_BITS:0] cfg_data,
	input  logic                cfg_valid,
	output logic                cfg_ready
);
	import scpb_pkg::*;

	cmd_t cmd;
	logic cmd_valid, cmd_ready;
	logic root_on_q;
	logic [RECORD_BITS-1:0] root_rec_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_on_q <= 1'b0;
			root_rec_q <= '0;
		end else if (cfg_valid) begin
			root_on_q <= !cfg_data[RECORD_BITS];
			root_rec_q <= cfg_data[RECORD_BITS-1:0];
		end
	end

	scpb_front u_front (
		.clk, .arst_n, .in_data, .in_valid, .in_ready,
		.cmd, .cmd_valid, .cmd_ready
	);

	scpb_back #(.SLOTS(SLOTS), .RECORD_BITS(RECORD_BITS)) u_back (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_ready,
		.root_on(root_on_q), .root_rec(root_rec_q),
		.out_data, .out_valid, .out_ready
	);
endmodule

// ===== hdl/scpb_front.sv =====
`timescale 1ns / 1ps
module scpb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  scpb_pkg::in_item_t  in_data,
	input  logic                in_valid,
	output logic                in_ready,
	output scpb_pkg::cmd_t      cmd,
	output logic                cmd_valid,
	input  logic                cmd_ready
);
	import scpb_pkg::*;

	cmd_t q_mem [QDEPTH];
	logic [1:0] cnt_q;
	logic wp_q, rp_q;
	cmd_t c;
	logic push, pop;

	always_comb begin
		c.rec = in_data.record_number;
		c.is_write = (in_data.mode == MODE_WRITE);
		case (in_data.mode)
			MODE_READ, MODE_WRITE: c.op = OP_ACCESS;
			MODE_FLUSH: c.op = OP_FLUSH;
			default: c.op = OP_NOP;
		endcase
	end

	assign in_ready = (cnt_q != 2'(QDEPTH));
	assign push = in_valid && in_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop = cmd_valid && cmd_ready;
	assign cmd = q_mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) q_mem[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== hdl/scpb_back.sv =====
`timescale 1ns / 1ps
module scpb_back #(
	parameter int SLOTS = scpb_pkg::SLOTS_DEF,
	parameter int RECORD_BITS = scpb_pkg::RECORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scpb_pkg::cmd_t       cmd,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  logic                 root_on,
	input  logic [RECORD_BITS-1:0] root_rec,
	output scpb_pkg::out_item_t  out_data,
	output logic                 out_valid,
	input  logic                 out_ready
);
	import scpb_pkg::*;
	localparam int SW = $clog2(SLOTS);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_FIND  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_SHIFT = 5'b01000,
		ST_FLUSH = 5'b10000
	} st_t;

	st_t st_q;
	logic [RECORD_BITS-1:0] tag_q [SLOTS];
	logic [SLOTS-1:0] tv_q, ref_q, dty_q;
	logic rs_v_q;
	logic [SW-1:0] rs_q;
	logic [31:0] hc_q, fc_q;
	cmd_t c_q;
	logic [SW-1:0] i_q;
	logic [SW+1:0] guard_q;
	logic found_q;
	logic ov_q;
	out_item_t od_q;

	logic [RECORD_BITS-1:0] rec;
	logic rec_root, busy_out;
	logic [SW-1:0] last_i;
	logic more_dirty;

	assign rec = c_q.rec[RECORD_BITS-1:0];
	assign rec_root = root_on && (root_rec == rec);
	assign busy_out = ov_q && !out_ready;
	assign cmd_ready = (st_q == ST_IDLE);
	assign out_valid = ov_q;
	assign out_data = od_q;
	assign last_i = SW'(SLOTS-1);

	always_comb begin
		more_dirty = 1'b0;
		for (int k = 0; k < SLOTS; k++)
			if (k > int'(i_q) && dty_q[k]) more_dirty = 1'b1;
	end

	function automatic out_item_t mk(logic h, logic [SW-1:0] s, logic wv,
			logic [RECORD_BITS-1:0] wr, logic [31:0] hc, logic [31:0] fc, logic l);
		out_item_t o;
		o.hit = h;
		o.slot = SLOT_W'(s);
		o.writeback_valid = wv;
		o.writeback_record = wv ? REC_W'(wr) : '0;
		o.hit_total = hc;
		o.fault_total = fc;
		o.last = l;
		return o;
	endfunction

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && cmd_valid) c_q <= cmd;
		if (st_q == ST_SHIFT && !busy_out) begin
			if (i_q != last_i) tag_q[i_q] <= tag_q[i_q + SW'(1)];
			else tag_q[i_q] <= rec;
		end
		if (st_q == ST_FIND && !busy_out && !found_q && !tv_q[i_q])
			tag_q[i_q] <= rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			tv_q <= '0;
			ref_q <= '0;
			dty_q <= '0;
			rs_v_q <= 1'b0;
			rs_q <= '0;
			hc_q <= '0;
			fc_q <= '0;
			i_q <= '0;
			guard_q <= '0;
			found_q <= 1'b0;
			ov_q <= 1'b0;
			od_q <= '0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (cmd_valid) begin
					i_q <= '0;
					found_q <= 1'b0;
					case (cmd.op)
						OP_ACCESS: st_q <= ST_FIND;
						OP_FLUSH: st_q <= ST_FLUSH;
						default: st_q <= ST_FLUSH;
					endcase
					if (cmd.op == OP_NOP) i_q <= last_i;
					if (cmd.op == OP_NOP) found_q <= 1'b1;
				end
				ST_FIND: if (!busy_out) begin
					if (tv_q[i_q] && tag_q[i_q] == rec) begin
						if (c_q.is_write) begin
							ref_q[i_q] <= 1'b1;
							dty_q[i_q] <= 1'b1;
							od_q <= mk(1'b1, i_q, 1'b0, '0, hc_q, fc_q, 1'b1);
						end else begin
							od_q <= mk(1'b1, i_q, 1'b0, '0,
								(hc_q == '1) ? hc_q : hc_q + 32'd1, fc_q, 1'b1);
							if (hc_q != '1) hc_q <= hc_q + 32'd1;
						end
						ov_q <= 1'b1;
						st_q <= ST_IDLE;
					end else if (!tv_q[i_q]) begin
						tv_q[i_q] <= 1'b1;
						ref_q[i_q] <= 1'b0;
						dty_q[i_q] <= 1'b0;
						if (rec_root) begin
							rs_v_q <= 1'b1;
							rs_q <= i_q;
						end
						if (!c_q.is_write && fc_q != '1) fc_q <= fc_q + 32'd1;
						od_q <= mk(1'b0, i_q, 1'b0, '0, hc_q,
							(!c_q.is_write && fc_q != '1) ? fc_q + 32'd1 : fc_q, 1'b1);
						ov_q <= 1'b1;
						st_q <= ST_IDLE;
					end else if (i_q == last_i) begin
						if (!c_q.is_write && fc_q != '1) fc_q <= fc_q + 32'd1;
						if (rec_root) rs_v_q <= 1'b0;
						i_q <= '0;
						guard_q <= '0;
						st_q <= ST_SCAN;
					end else begin
						i_q <= i_q + SW'(1);
					end
				end
				ST_SCAN: if (!busy_out) begin
					if ((ref_q[i_q] || (rs_v_q && rs_q == i_q)) &&
							guard_q != (SW+2)'(2*SLOTS)) begin
						ref_q[i_q] <= 1'b0;
						guard_q <= guard_q + (SW+2)'(1);
						i_q <= (i_q == last_i) ? '0 : i_q + SW'(1);
					end else begin
						od_q <= mk(1'b0, last_i, dty_q[i_q], tag_q[i_q], hc_q, fc_q, 1'b1);
						st_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: if (!busy_out) begin
					if (i_q != last_i) begin
						tv_q[i_q] <= tv_q[i_q + SW'(1)];
						ref_q[i_q] <= ref_q[i_q + SW'(1)];
						dty_q[i_q] <= dty_q[i_q + SW'(1)];
						if (rs_v_q && rs_q == i_q + SW'(1)) rs_q <= i_q;
						i_q <= i_q + SW'(1);
					end else begin
						tv_q[i_q] <= 1'b1;
						ref_q[i_q] <= 1'b0;
						dty_q[i_q] <= 1'b0;
						if (rec_root) begin
							rs_v_q <= 1'b1;
							rs_q <= i_q;
						end
						ov_q <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
				ST_FLUSH: if (!busy_out) begin
					if (found_q && i_q == last_i) begin
						od_q <= mk(1'b0, '0, 1'b0, '0, hc_q, fc_q, 1'b1);
						ov_q <= 1'b1;
						st_q <= ST_IDLE;
					end else if (dty_q[i_q]) begin
						dty_q[i_q] <= 1'b0;
						od_q <= mk(1'b0, i_q, 1'b1, tag_q[i_q], hc_q, fc_q, !more_dirty);
						ov_q <= 1'b1;
						if (!more_dirty) st_q <= ST_IDLE;
						else i_q <= i_q + SW'(1);
					end else if (i_q == last_i) begin
						od_q <= mk(1'b0, '0, 1'b0, '0, hc_q, fc_q, 1'b1);
						ov_q <= 1'b1;
						st_q <= ST_IDLE;
					end else begin
						i_q <= i_q + SW'(1);
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/scpb_checker.sv =====
`timescale 1ns / 1ps
module scpb_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input scpb_pkg::out_item_t out_data
);
	import scpb_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");
	a_wb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.writeback_valid |-> out_data.writeback_record == '0)
		else $error("writeback record without writeback");
	a_hit_nowb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit |-> !out_data.writeback_valid && out_data.last)
		else $error("hit with writeback");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready ##1 out_valid |->
		out_data.hit_total >= $past(out_data.hit_total))
		else $error("hit counter went down");
endmodule

bind second_chance_page_buffer_top scpb_checker u_chk (
	.clk, .arst_n, .out_valid, .out_ready, .out_data
);

// ===== dv/second_chance_page_buffer_top_test.sv =====
`timescale 1ns / 1ps
module second_chance_page_buffer_top_test;
	import scpb_pkg::*;

	localparam int NSLOT = SLOTS_DEF;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	in_item_t in_data;
	logic in_valid;
	logic in_ready;
	out_item_t out_data;
	logic out_valid;
	logic out_ready;
	logic [REC_W:0] cfg_data;
	logic cfg_valid;
	logic cfg_ready;

	second_chance_page_buffer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_data(out_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cfg_data(cfg_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready)
	);

	// buffer tag shadow
	logic [REC_W-1:0] tag_q[NSLOT];
	logic tag_used[NSLOT];
	logic ref_bit[NSLOT];
	logic dirty_bit[NSLOT];
	int pinned_slot;
	logic [REC_W-1:0] root_rec;
	logic root_on;
	logic [31:0] read_hits;
	logic [31:0] read_faults;

	out_item_t beat_q[$];
	int mismatches;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_left;
	bit stall_req;
	int quiet_cycles;
	logic [REC_W-1:0] rec_pool[12];

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic void push_beat(logic h, int s, logic wbv, logic [REC_W-1:0] wbr, logic l);
		out_item_t r;
		r.hit = h;
		r.slot = s[SLOT_W-1:0];
		r.writeback_valid = wbv;
		r.writeback_record = wbv ? wbr : '0;
		r.hit_total = read_hits;
		r.fault_total = read_faults;
		r.last = l;
		beat_q.push_back(r);
	endfunction

	function automatic void page_insert(logic [REC_W-1:0] rec);
		int i;
		logic wbv;
		logic [REC_W-1:0] wbr;
		wbv = 0;
		wbr = '0;
		i = 0;
		while (i < NSLOT && tag_used[i]) i++;
		if (i == NSLOT) begin
			if (root_on && root_rec == rec) pinned_slot = -1;
			i = 0;
			for (int g = 0; g < 2 * NSLOT + 1; g++) begin
				if (!(ref_bit[i] || pinned_slot == i)) break;
				ref_bit[i] = 0;
				i = (i + 1) % NSLOT;
			end
			if (dirty_bit[i]) begin
				wbv = 1;
				wbr = tag_q[i];
			end
			for (; i < NSLOT - 1; i++) begin
				tag_q[i] = tag_q[i+1];
				tag_used[i] = tag_used[i+1];
				ref_bit[i] = ref_bit[i+1];
				dirty_bit[i] = dirty_bit[i+1];
				if (pinned_slot == i + 1) pinned_slot = i;
			end
			i = NSLOT - 1;
		end
		tag_q[i] = rec;
		tag_used[i] = 1;
		ref_bit[i] = 0;
		dirty_bit[i] = 0;
		if (root_on && root_rec == rec) pinned_slot = i;
		push_beat(0, i, wbv, wbr, 1);
	endfunction

	function automatic void predict_access(in_item_t it);
		int s;
		int last_d;
		s = -1;
		last_d = -1;
		if (it.mode == MODE_READ || it.mode == MODE_WRITE) begin
			for (int i = 0; i < NSLOT; i++)
				if (s < 0 && tag_used[i] && tag_q[i] == it.record_number) s = i;
			if (s >= 0) begin
				if (it.mode == MODE_READ) begin
					if (read_hits != 32'hFFFF_FFFF) read_hits++;
				end else begin
					ref_bit[s] = 1;
					dirty_bit[s] = 1;
				end
				push_beat(1, s, 0, '0, 1);
			end else begin
				if (it.mode == MODE_READ && read_faults != 32'hFFFF_FFFF) read_faults++;
				page_insert(it.record_number);
			end
		end else if (it.mode == MODE_FLUSH) begin
			for (int i = 0; i < NSLOT; i++)
				if (dirty_bit[i]) last_d = i;
			if (last_d < 0) push_beat(0, 0, 0, '0, 1);
			for (int i = 0; i < NSLOT; i++)
				if (dirty_bit[i]) begin
					dirty_bit[i] = 0;
					push_beat(0, i, 1, tag_q[i], i == last_d);
				end
		end else begin
			push_beat(0, 0, 0, '0, 1);
		end
	endfunction

	task automatic send_beat(input logic [1:0] m, input logic [REC_W-1:0] rec);
		in_item_t it;
		it.mode = m;
		it.record_number = rec;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_data <= it;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		predict_access(it);
		@(negedge clk);
	endtask

	task automatic stop_sending();
		in_valid <= 0;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (beat_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_root(input logic [REC_W:0] v);
		cfg_data <= v;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		root_on = !v[REC_W];
		root_rec = v[REC_W] ? '0 : v[REC_W-1:0];
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	function automatic logic [REC_W-1:0] pick_rec();
		if ($urandom_range(99) < 8) return REC_W'($urandom);
		return rec_pool[$urandom_range(11)];
	endfunction

	function automatic logic [1:0] pick_mode();
		int r;
		r = $urandom_range(99);
		if (r < 47) return MODE_READ;
		if (r < 84) return MODE_WRITE;
		if (r < 97) return MODE_FLUSH;
		return MODE_UNUSED;
	endfunction

	task automatic new_pool();
		foreach (rec_pool[i]) rec_pool[i] = REC_W'($urandom);
	endtask

	task automatic test_directed();
		wait_idle();
		write_root({1'b0, 16'hFFFF});
		send_beat(MODE_FLUSH, 16'h0);
		send_beat(MODE_READ, 16'hFFFF);
		send_beat(MODE_READ, 16'hFFFF);
		for (int i = 0; i < NSLOT - 1; i++) send_beat(MODE_READ, 16'(i));
		send_beat(MODE_WRITE, 16'h0001);
		send_beat(MODE_WRITE, 16'hFFFF);
		send_beat(MODE_READ, 16'h0100);
		send_beat(MODE_WRITE, 16'h0003);
		send_beat(MODE_WRITE, 16'h8000);
		send_beat(MODE_READ, 16'h0200);
		send_beat(MODE_FLUSH, 16'hFFFF);
		send_beat(MODE_FLUSH, 16'h0);
		send_beat(MODE_UNUSED, 16'h5555);
		send_beat(MODE_WRITE, 16'hAAAA);
		send_beat(MODE_READ, 16'h0100);
		stop_sending();
		wait_idle();
		write_root({1'b0, 16'h0000});
		send_beat(MODE_READ, 16'h0000);
		send_beat(MODE_WRITE, 16'h7777);
		send_beat(MODE_FLUSH, 16'h0);
		stop_sending();
	endtask

	task automatic test_random(input int n, input int s_pct, input int r_pct,
		input logic [REC_W:0] root_v);
		wait_idle();
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		new_pool();
		write_root(root_v);
		for (int i = 0; i < n; i++) begin
			send_beat(pick_mode(), pick_rec());
			if (i == n / 2) begin
				// sender waits for every result mid-run
				stop_sending();
				wait_idle();
			end
		end
		stop_sending();
	endtask

	task automatic test_backpressure();
		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_req = 1;
		for (int i = 0; i < 30; i++) send_beat(pick_mode(), pick_rec());
		stop_sending();
	endtask

	// receiver ready with optional long hold-off
	always @(negedge clk) begin
		if (stall_req) begin
			stall_left = 400;
			stall_req = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			if (beat_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %p", out_data);
			end else begin
				e = beat_q.pop_front();
				if (out_data.hit !== e.hit || out_data.slot !== e.slot ||
					out_data.writeback_valid !== e.writeback_valid ||
					out_data.writeback_record !== e.writeback_record ||
					out_data.hit_total !== e.hit_total ||
					out_data.fault_total !== e.fault_total ||
					out_data.last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", e, out_data);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_valid = 0;
		cfg_data = '1;
		out_ready = 0;
		mismatches = 0;
		quiet_cycles = 0;
		stall_left = 0;
		stall_req = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < NSLOT; i++) begin
			tag_q[i] = '0;
			tag_used[i] = 0;
			ref_bit[i] = 0;
			dirty_bit[i] = 0;
		end
		pinned_slot = -1;
		root_rec = '0;
		root_on = 0;
		read_hits = '0;
		read_faults = '0;
		new_pool();
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_random(110, 6, 52, {1'b1, 16'hFFFF});
		test_random(110, 52, 6, {1'b0, 16'h0000});
		test_random(110, 0, 0, {1'b1, 16'h0000});
		new_pool();
		wait_idle();
		write_root({1'b0, rec_pool[0]});
		test_backpressure();
		wait_idle();
		write_root({1'b0, 16'hFFFF});
		if (mismatches == 0 && beat_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
